// ----- src/i2c_master_register_access_assert.svh -----
// Assertion macros for the I2C register access master.
// Used by the top level; no other dependencies.
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define I2CM_ASSERT_IMP(label, clock, rstn, lhs, rhs) \
	label: assert property (@(posedge clock) disable iff (!rstn) (lhs) |-> (rhs)) \
		else $error("i2cm assertion failed");
// next-cycle implication
`define I2CM_ASSERT_NXT(label, clock, rstn, lhs, rhs) \
	label: assert property (@(posedge clock) disable iff (!rstn) (lhs) |=> (rhs)) \
		else $error("i2cm assertion failed");
`else
`define I2CM_ASSERT_IMP(label, clock, rstn, lhs, rhs)
`define I2CM_ASSERT_NXT(label, clock, rstn, lhs, rhs)
`endif

`endif

// ----- src/i2cm_pkg.sv -----
// Package for the I2C register access master: opcodes, mode and register
// codes, and the command program table. No dependencies.
package i2cm_pkg;

	typedef enum logic [3:0] {
		OP_STOP      = 4'd0,
		OP_SEND_AW   = 4'd1,
		OP_SEND_AR   = 4'd2,
		OP_SEND_REG  = 4'd3,
		OP_SEND_HI   = 4'd4,
		OP_SEND_LO   = 4'd5,
		OP_SEND_SCAN = 4'd6,
		OP_START     = 4'd7,
		OP_RACK      = 4'd8,
		OP_RBYTE     = 4'd9,
		OP_WACK0     = 4'd10,
		OP_WACK1     = 4'd11
	} op_t;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_PROBE = 2'd2;
	localparam logic [1:0] MODE_SCAN  = 2'd3;

	localparam logic REG_DEVICE_ADDRESS = 1'b0;
	localparam logic REG_WIDE_DATA      = 1'b1;

	localparam logic [4:0] SEQ_IDLE = 5'd31;
	localparam logic [6:0] SCAN_LAST = 7'd127;

	// program index from command mode and data width
	function automatic logic [2:0] prog_id(input logic [1:0] mode, input logic wide);
		logic [2:0] id;
		case (mode)
			MODE_WRITE: id = wide ? 3'd1 : 3'd0;
			MODE_READ:  id = wide ? 3'd3 : 3'd2;
			MODE_PROBE: id = 3'd4;
			default:    id = 3'd5;
		endcase
		return id;
	endfunction

	// primitive at a given step of a program; unused slots are stop
	function automatic op_t prog_op(input logic [2:0] id, input logic [3:0] step);
		op_t op;
		op = OP_STOP;
		case (step)
			4'd0: op = OP_START;
			4'd1: op = (id == 3'd5) ? OP_SEND_SCAN : OP_SEND_AW;
			4'd2: op = OP_RACK;
			4'd3: op = (id > 3'd3) ? OP_STOP : OP_SEND_REG;
			4'd4: op = (id > 3'd3) ? OP_STOP : OP_RACK;
			4'd5: case (id)
				3'd0:    op = OP_SEND_LO;
				3'd1:    op = OP_SEND_HI;
				3'd2,
				3'd3:    op = OP_START;
				default: op = OP_STOP;
			endcase
			4'd6: case (id)
				3'd0,
				3'd1:    op = OP_RACK;
				3'd2,
				3'd3:    op = OP_SEND_AR;
				default: op = OP_STOP;
			endcase
			4'd7: case (id)
				3'd1:    op = OP_SEND_LO;
				3'd2,
				3'd3:    op = OP_RACK;
				default: op = OP_STOP;
			endcase
			4'd8: case (id)
				3'd1:    op = OP_RACK;
				3'd2,
				3'd3:    op = OP_RBYTE;
				default: op = OP_STOP;
			endcase
			4'd9: case (id)
				3'd2:    op = OP_WACK1;
				3'd3:    op = OP_WACK0;
				default: op = OP_STOP;
			endcase
			4'd10: op = (id == 3'd3) ? OP_RBYTE : OP_STOP;
			4'd11: op = (id == 3'd3) ? OP_WACK1 : OP_STOP;
			default: op = OP_STOP;
		endcase
		return op;
	endfunction

endpackage

// ----- src/i2c_master_register_access.sv -----
// Top level of the bit-level I2C master for 7-bit register access.
// Depends on i2cm_pkg and i2c_master_register_access_assert.svh.
//
// Usage: every request on the slave stream is one pin step. The block moves
// SCL or SDA by at most one level per step and returns one result per request
// on the master stream with the driven line levels, busy/done flags and the
// read value, probe ACK bit and scan address.
// A request with go=1 while idle starts the command selected by s_tuser
// (write, read, probe, scan); go is ignored while a command runs.
// Configuration (device address, 16-bit data flag) is written through
// cfg_wen/cfg_index/cfg_wdata and is sampled when a command starts (width)
// or whenever an address byte is loaded (device address).
// Latency: the result of a request is on m_tdata the cycle after acceptance.
// Throughput: one request per clock while s_tready is high; the step logic is one pass
// of small next-state logic from the state registers to the result register.
// The result register is one deep; s_tready falls only while it holds an
// untaken result and m_tready is low, so a stalled receiver holds the input.
// Reset: idle, lines released (SCL=1, SDA=1), ACK latch 1, no result pending.
module i2c_master_register_access (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // go, reg_address[7:0], write_data[15:0], sda_in, zero pad
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // scl_out, sda_out, busy_res, done_res, read_data[15:0],
	                               // ack_bit, found_address[6:0], zero pad
	input  logic        cfg_wen,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_wdata
);
	import i2cm_pkg::*;

	// configuration
	logic [6:0]  dev_addr_q;
	logic        wide_cfg_q;

	// sequencer state
	logic [4:0]  seq_q, seq_d;
	logic [1:0]  ph_q, ph_d;
	logic [3:0]  bi_q, bi_d;
	logic [7:0]  sb_q, sb_d;
	logic [6:0]  scan_q, scan_d;
	logic [15:0] acc_q, acc_d;
	logic [1:0]  mode_q, mode_d;
	logic        ack_q, ack_d;
	logic        wide_q, wide_d;
	logic [7:0]  reg_q, reg_d;
	logic [15:0] data_q, data_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        done_d;

	// result register
	logic        out_valid_q;
	logic        out_scl_q, out_sda_q, out_busy_q, out_done_q, out_ack_q;
	logic [15:0] out_rd_q;
	logic [6:0]  out_found_q;

	// input fields
	logic        in_go, in_sda;
	logic [7:0]  in_reg;
	logic [15:0] in_data;
	logic        accept;

	assign in_go   = s_tdata[0];
	assign in_reg  = s_tdata[8:1];
	assign in_data = s_tdata[24:9];
	assign in_sda  = s_tdata[25];

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_found_q, out_ack_q, out_rd_q,
	                   out_done_q, out_busy_q, out_sda_q, out_scl_q};

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= '0;
			wide_cfg_q <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_DEVICE_ADDRESS: dev_addr_q <= cfg_wdata;
				REG_WIDE_DATA:      wide_cfg_q <= cfg_wdata[0];
				default:            ;
			endcase
		end
	end

	// one pin step
	always_comb begin
		op_t        op;
		logic [1:0] nxt;
		logic [3:0] bi_inc;
		logic       adv;
		logic       fin;
		logic [7:0] send_byte;

		seq_d  = seq_q;
		ph_d   = ph_q;
		bi_d   = bi_q;
		sb_d   = sb_q;
		scan_d = scan_q;
		acc_d  = acc_q;
		mode_d = mode_q;
		ack_d  = ack_q;
		wide_d = wide_q;
		reg_d  = reg_q;
		data_d = data_q;
		scl_d  = scl_q;
		sda_d  = sda_q;
		done_d = 1'b0;
		adv    = 1'b0;
		fin    = 1'b0;

		// command start
		if (seq_q == SEQ_IDLE && in_go) begin
			mode_d = s_tuser;
			wide_d = wide_cfg_q;
			reg_d  = in_reg;
			data_d = in_data;
			if (s_tuser == MODE_READ) acc_d = '0;
			if (s_tuser == MODE_SCAN) scan_d = 7'd1;
			seq_d = '0;
			ph_d  = '0;
			bi_d  = '0;
		end

		op     = prog_op(prog_id(mode_d, wide_d), seq_d[3:0]);
		nxt    = ph_d + 2'd1;
		bi_inc = bi_d + 4'd1;

		case (op)
			OP_SEND_AW:   send_byte = {dev_addr_q, 1'b0};
			OP_SEND_AR:   send_byte = {dev_addr_q, 1'b1};
			OP_SEND_REG:  send_byte = reg_d;
			OP_SEND_HI:   send_byte = data_d[15:8];
			OP_SEND_LO:   send_byte = data_d[7:0];
			default:      send_byte = {scan_d, 1'b0};
		endcase

		if (seq_d != SEQ_IDLE) begin
			case (op)
				OP_START: begin
					case (ph_d)
						2'd0: sda_d = 1'b1;
						2'd1: scl_d = 1'b1;
						2'd2: sda_d = 1'b0;
						default: begin
							scl_d = 1'b0;
							adv   = 1'b1;
						end
					endcase
				end
				OP_RACK: begin
					case (ph_d)
						2'd0: sda_d = 1'b1;
						2'd1: scl_d = 1'b1;
						default: begin
							scl_d = 1'b0;
							ack_d = in_sda;
							adv   = 1'b1;
						end
					endcase
				end
				OP_WACK0, OP_WACK1: begin
					case (ph_d)
						2'd0: sda_d = (op == OP_WACK1);
						2'd1: scl_d = 1'b1;
						default: begin
							scl_d = 1'b0;
							adv   = 1'b1;
						end
					endcase
				end
				OP_RBYTE: begin
					case (ph_d)
						2'd0: begin
							sda_d = 1'b1;
							sb_d  = '0;
							bi_d  = '0;
						end
						2'd1: scl_d = 1'b1;
						default: begin
							scl_d = 1'b0;
							sb_d  = {sb_d[6:0], in_sda};
							if (bi_inc >= 4'd8) begin
								acc_d = {acc_d[7:0], sb_d};
								bi_d  = '0;
								adv   = 1'b1;
							end else begin
								bi_d = bi_inc;
								nxt  = 2'd1;
							end
						end
					endcase
				end
				OP_STOP: begin
					case (ph_d)
						2'd0: sda_d = 1'b0;
						2'd1: scl_d = 1'b1;
						default: begin
							sda_d = 1'b1;
							fin   = 1'b1;
						end
					endcase
				end
				default: begin
					// byte send, MSB first
					case (ph_d)
						2'd0: begin
							if (bi_d == 4'd0) sb_d = send_byte;
							sda_d = sb_d[7];
						end
						2'd1: scl_d = 1'b1;
						default: begin
							scl_d = 1'b0;
							sb_d  = {sb_d[6:0], 1'b0};
							if (bi_inc >= 4'd8) begin
								bi_d = '0;
								adv  = 1'b1;
							end else begin
								bi_d = bi_inc;
								nxt  = 2'd0;
							end
						end
					endcase
				end
			endcase

			ph_d = nxt;
			if (adv) begin
				seq_d = {1'b0, seq_d[3:0] + 4'd1};
				ph_d  = '0;
			end
			if (fin) begin
				ph_d = '0;
				bi_d = '0;
				if (mode_d == MODE_SCAN && ack_d && scan_d < SCAN_LAST) begin
					// no answer yet: next address
					scan_d = scan_d + 7'd1;
					seq_d  = '0;
				end else begin
					if (mode_d == MODE_SCAN && ack_d) scan_d = '0;
					seq_d  = SEQ_IDLE;
					done_d = 1'b1;
				end
			end
		end
	end

	// state registers advance on every accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= SEQ_IDLE;
			ph_q   <= '0;
			bi_q   <= '0;
			sb_q   <= '0;
			scan_q <= '0;
			acc_q  <= '0;
			mode_q <= '0;
			ack_q  <= 1'b1;
			wide_q <= 1'b0;
			reg_q  <= '0;
			data_q <= '0;
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
		end else if (accept) begin
			seq_q  <= seq_d;
			ph_q   <= ph_d;
			bi_q   <= bi_d;
			sb_q   <= sb_d;
			scan_q <= scan_d;
			acc_q  <= acc_d;
			mode_q <= mode_d;
			ack_q  <= ack_d;
			wide_q <= wide_d;
			reg_q  <= reg_d;
			data_q <= data_d;
			scl_q  <= scl_d;
			sda_q  <= sda_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_scl_q   <= scl_d;
			out_sda_q   <= sda_d;
			out_busy_q  <= (seq_d != SEQ_IDLE);
			out_done_q  <= done_d;
			out_rd_q    <= acc_d;
			out_ack_q   <= ack_d;
			out_found_q <= scan_d;
		end
	end

`include "i2c_master_register_access_assert.svh"

	`I2CM_ASSERT_IMP(a_done_not_busy, clk, arst_n, out_valid_q && out_done_q, !out_busy_q)
	`I2CM_ASSERT_IMP(a_done_bus_free, clk, arst_n, out_valid_q && out_done_q, out_scl_q && out_sda_q)
	`I2CM_ASSERT_IMP(a_idle_phase, clk, arst_n, seq_q == SEQ_IDLE, ph_q == 2'd0)
	`I2CM_ASSERT_IMP(a_bit_range, clk, arst_n, 1'b1, bi_q < 4'd8)
	`I2CM_ASSERT_IMP(a_scan_addr, clk, arst_n, seq_q != SEQ_IDLE && mode_q == MODE_SCAN, scan_q != 7'd0)
	`I2CM_ASSERT_NXT(a_idle_hold, clk, arst_n, seq_q == SEQ_IDLE && !(accept && in_go), seq_q == SEQ_IDLE)

endmodule
